>>> sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// shared types, codes and ring helper for the double-ended queue
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT   = 3'd0,
    CMD_PUSH_BACK    = 3'd1,
    CMD_REMOVE_FRONT = 3'd2,
    CMD_REMOVE_BACK  = 3'd3,
    CMD_DUMP         = 3'd4
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_code_t;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] entry;
    logic                     last;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic dump_clear;  // restart dump walk at the front
    logic rd_en;       // read slot at front + walk index
    logic emit;        // load read data into output register, advance walk
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic dump_last;
    logic out_free;
  } dp_status_t;

  // (base + off) mod CAPACITY, base < CAPACITY and off <= CAPACITY
  function automatic idx_t ring_add(idx_t base, cnt_t off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

>>> sv/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// sequencer: single-beat commands in idle, slot-by-slot walk for a dump
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         command,
  input  deq_pkg::dp_status_t status,
  output deq_pkg::dp_cmd_t    cmd
);
  import deq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE      = 3'b001,
    S_DUMP_RD   = 3'b010,
    S_DUMP_WAIT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   take;

  assign in_ready = (state == S_IDLE) && status.out_free;
  assign take     = in_valid && in_ready;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    unique case (state)
      S_IDLE: begin
        cmd.accept = take;
        if (take && command == CMD_DUMP && !status.empty) begin
          cmd.dump_clear = 1'b1;
          state_next     = S_DUMP_RD;
        end
      end
      S_DUMP_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_DUMP_WAIT;
      end
      S_DUMP_WAIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = status.dump_last ? S_IDLE : S_DUMP_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/deq_dp.sv
// ----------------------------------------------------------------------------
// deq_dp
// ring indices, slot store and output register
// ----------------------------------------------------------------------------
module deq_dp (
  input  logic                clk,
  input  logic                rst,
  input  deq_pkg::in_beat_t   in_data,
  input  deq_pkg::dp_cmd_t    cmd,
  output deq_pkg::dp_status_t status,
  output logic                out_valid,
  input  logic                out_ready,
  output deq_pkg::out_beat_t  out_data
);
  import deq_pkg::*;

  idx_t front, front_next;
  cnt_t count, count_next;
  idx_t walk;

  logic              full;
  logic              empty;
  logic              wr_en;
  idx_t              wr_addr;
  idx_t              rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic              load;
  out_beat_t         result;

  assign full  = (count == cnt_t'(CAPACITY));
  assign empty = (count == '0);

  assign status.empty     = empty;
  assign status.dump_last = ((CNT_W'(walk) + cnt_t'(1)) == count);
  assign status.out_free  = !out_valid || out_ready;

  assign rd_addr = ring_add(front, CNT_W'(walk));

  // single-beat commands and dump walk output loads
  always_comb begin
    front_next = front;
    count_next = count;
    wr_en      = 1'b0;
    wr_addr    = ring_add(front, count);
    load       = 1'b0;
    result     = '{status: ST_OK, entry: '0, last: 1'b1};
    if (cmd.accept) begin
      unique case (in_data.command)
        CMD_PUSH_FRONT: begin
          load = 1'b1;
          if (full) begin
            result.status = ST_FULL;
          end else begin
            front_next = (front == '0) ? idx_t'(CAPACITY - 1) : front - idx_t'(1);
            wr_addr    = front_next;
            wr_en      = 1'b1;
            count_next = count + cnt_t'(1);
          end
        end
        CMD_PUSH_BACK: begin
          load = 1'b1;
          if (full) begin
            result.status = ST_FULL;
          end else begin
            wr_en      = 1'b1;
            count_next = count + cnt_t'(1);
          end
        end
        CMD_REMOVE_FRONT: begin
          load = 1'b1;
          if (empty) begin
            result.status = ST_EMPTY;
          end else begin
            front_next = (front == idx_t'(CAPACITY - 1)) ? '0 : front + idx_t'(1);
            count_next = count - cnt_t'(1);
          end
        end
        CMD_REMOVE_BACK: begin
          load = 1'b1;
          if (empty) begin
            result.status = ST_EMPTY;
          end else begin
            count_next = count - cnt_t'(1);
          end
        end
        CMD_DUMP: begin
          // a non-empty dump is walked by the controller
          load          = empty;
          result.status = ST_EMPTY;
        end
        default: load = 1'b0;
      endcase
    end else if (cmd.emit) begin
      load         = 1'b1;
      result.entry = rd_data;
      result.last  = status.dump_last;
    end
  end

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      walk      <= '0;
      out_valid <= 1'b0;
    end else begin
      front <= front_next;
      count <= count_next;
      if (cmd.dump_clear) begin
        walk <= '0;
      end else if (cmd.emit) begin
        walk <= walk + idx_t'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= result;
    end
  end

endmodule

>>> sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed 32-bit entries in a ring store
// ----------------------------------------------------------------------------
// usage
//   in channel  (in_valid/in_ready/in_data): one beat per command, push front,
//     push back, remove front, remove back or dump; value only used by pushes
//   out channel (out_valid/out_ready/out_data): status, entry and last
//   push and remove give one result beat, registered in the cycle after the
//     input beat; a new command can be taken every cycle while out_ready holds
//   a dump of n entries gives n beats front to back, each a slot read then an
//     output load on the single ram read port, the load waiting for a free output
//     register, last set on the final one; an empty dump gives one empty-status beat
//   no input is taken during a dump walk
//   unknown command codes are consumed and give no result
//   reset clears front index, count and the output valid flag; the slot ram
//     needs no clearing pass, only written slots are ever read
//   when out_ready is low the result waits in the output register and
//     in_ready drops until it is taken
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  deq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output deq_pkg::out_beat_t out_data
);
  import deq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // controller: idle command decode and dump sequencing
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (in_data.command),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: indices, slot ram, output register
  deq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> test/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// self-checking bench for the bounded double-ended queue: a mirror deque
// predicts every result beat, a monitor compares them field by field, and
// the traffic runs through empty and full corners, ring wrap, empty, full and
// random-length dumps, output back-pressure and random bursty command streams
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int RANDOM_ITEMS = 110;
  localparam int HOLD_CYCLES  = 60;
  localparam int TAIL_CYCLES  = 50;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int LIMIT_CYCLES = 300000;

  // codes 5..7 are not commands, the block swallows them
  localparam logic [2:0] FIRST_UNUSED_CMD = 3'(CMD_DUMP) + 3'd1;

  typedef enum int {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  double_ended_queue uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the deque contents, updated when a command beat is taken
  logic signed [DATA_W-1:0] mirror_slot [CAPACITY];
  int mirror_front = 0;
  int mirror_count = 0;

  // result beats the block still owes, oldest first
  out_beat_t due_replies [$];
  out_beat_t want;

  int  n_sent = 0;
  int  n_checked = 0;
  int  n_dumps = 0;
  int  n_full = 0;
  int  n_empty = 0;
  int  n_errors = 0;
  int  n_in_stalls = 0;
  int  cycle_count = 0;
  int  burst_left = 1;
  bit  hold_req = 1'b0;

  // ---------------------------------------------------------------------------
  // mirror update: apply one accepted command and queue the beats it owes
  // ---------------------------------------------------------------------------
  task automatic apply_command(in_beat_t beat);
    out_beat_t r;
    int i;
    r = '0;
    r.last = 1'b1;
    case (beat.command)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (mirror_count == CAPACITY) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          if (beat.command == CMD_PUSH_FRONT) begin
            mirror_front = (mirror_front + CAPACITY - 1) % CAPACITY;
            mirror_slot[mirror_front] = beat.value;
          end else begin
            mirror_slot[(mirror_front + mirror_count) % CAPACITY] = beat.value;
          end
          mirror_count++;
          r.status = ST_OK;
        end
        due_replies.push_back(r);
      end
      CMD_REMOVE_FRONT, CMD_REMOVE_BACK: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          // removed entry is dropped, no data comes back
          if (beat.command == CMD_REMOVE_FRONT) begin
            mirror_front = (mirror_front + 1) % CAPACITY;
          end
          mirror_count--;
          r.status = ST_OK;
        end
        due_replies.push_back(r);
      end
      CMD_DUMP: begin
        n_dumps++;
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
          n_empty++;
          due_replies.push_back(r);
        end else begin
          // one beat per entry, front to back, last flag on the final one
          for (i = 0; i < mirror_count; i++) begin
            r.status = ST_OK;
            r.entry  = mirror_slot[(mirror_front + i) % CAPACITY];
            r.last   = (i == mirror_count - 1);
            due_replies.push_back(r);
          end
        end
      end
      default: begin
        // unknown code: no state change, no result
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // sender: one command beat, valid held until taken, bursts with gaps
  // ---------------------------------------------------------------------------
  task automatic send_cmd(logic [2:0] cmd, logic signed [DATA_W-1:0] val);
    in_beat_t beat;
    int gap;
    beat.command = cmd;
    beat.value   = val;
    in_data  <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_command(beat);
    n_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      2:       return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  // growing phases lean on pushes, shrinking phases on removes
  function automatic logic [2:0] pick_command(bit growing);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      return FIRST_UNUSED_CMD + 3'($urandom_range(0, 2));
    end
    if (roll < 14) begin
      return CMD_DUMP;
    end
    if (growing ? (roll < 74) : (roll < 34)) begin
      return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? CMD_REMOVE_BACK : CMD_REMOVE_FRONT;
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: stall pattern of its own, plus a long hold on request
  // ---------------------------------------------------------------------------
  initial begin : receiver
    rx_mode_t mode;
    int left;
    int tick;
    mode = RX_STEADY;
    left = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        // long hold-off so the output register backs up into the input
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 2));
          left = $urandom_range(16, 64);
        end
        left--;
        tick++;
        case (mode)
          RX_STEADY:   out_ready <= 1'b1;
          RX_RANDOM:   out_ready <= ($urandom_range(0, 2) != 0);
          RX_PERIODIC: out_ready <= ((tick % 7) < 4);
          default:     out_ready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result beat against the oldest owed beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && !in_ready) begin
      n_in_stalls++;
    end
    if (!rst && out_valid && out_ready) begin
      if (due_replies.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got status=%0d entry=%0d last=%0b",
                 $time, out_data.status, out_data.entry, out_data.last);
        n_errors++;
      end else begin
        want = due_replies.pop_front();
        n_checked++;
        if (out_data.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, out_data.status);
          n_errors++;
        end
        if (out_data.entry !== want.entry) begin
          $display("%0t: entry mismatch, expected %0d, got %0d",
                   $time, want.entry, out_data.entry);
          n_errors++;
        end
        if (out_data.last !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b",
                   $time, want.last, out_data.last);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // empty replies, value extremes, every command, unknown codes
  task automatic test_empty_and_edges();
    send_cmd(CMD_DUMP, '0);
    send_cmd(CMD_REMOVE_FRONT, '0);
    send_cmd(CMD_REMOVE_BACK, '1);
    send_cmd(CMD_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
    send_cmd(CMD_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}});
    send_cmd(CMD_PUSH_FRONT, '0);
    send_cmd(CMD_PUSH_BACK, '1);
    send_cmd(CMD_PUSH_FRONT, 1);
    send_cmd(CMD_DUMP, '1);
    send_cmd(CMD_REMOVE_FRONT, '0);
    send_cmd(CMD_REMOVE_BACK, '0);
    send_cmd(CMD_DUMP, '0);
    // unknown codes must leave the contents alone
    send_cmd(FIRST_UNUSED_CMD, '1);
    send_cmd(FIRST_UNUSED_CMD + 3'd1, '0);
    send_cmd(FIRST_UNUSED_CMD + 3'd2, '1);
    send_cmd(CMD_DUMP, '0);
    send_cmd(CMD_REMOVE_FRONT, '0);
    send_cmd(CMD_REMOVE_BACK, '0);
    send_cmd(CMD_REMOVE_FRONT, '0);
    send_cmd(CMD_REMOVE_BACK, '0);
    send_cmd(CMD_DUMP, '0);
  endtask

  // fill to capacity from both ends, refused pushes, wrap of both indices
  task automatic test_full_and_wrap();
    int i;
    i = 0;
    while (mirror_count < CAPACITY) begin
      send_cmd((i % 3 == 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
      i++;
    end
    send_cmd(CMD_PUSH_FRONT, pick_value());
    send_cmd(CMD_PUSH_BACK, pick_value());
    send_cmd(CMD_DUMP, '0);
    for (i = 0; i < 4; i++) begin
      send_cmd(CMD_REMOVE_FRONT, '0);
    end
    for (i = 0; i < 4; i++) begin
      send_cmd(CMD_PUSH_BACK, pick_value());
    end
    send_cmd(CMD_DUMP, '0);
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_output_backpressure();
    int i;
    hold_req = 1'b1;
    for (i = 0; i < 20; i++) begin
      case (i % 5)
        0, 1:    send_cmd(CMD_REMOVE_BACK, '0);
        2:       send_cmd(CMD_PUSH_FRONT, pick_value());
        3:       send_cmd(CMD_REMOVE_FRONT, '0);
        default: send_cmd(CMD_DUMP, '0);
      endcase
    end
  endtask

  // random traffic swinging between empty and full
  task automatic test_random_traffic();
    int done;
    bit growing;
    logic [2:0] cmd;
    done = 0;
    growing = 1'b1;
    while (done < RANDOM_ITEMS) begin
      if (mirror_count == CAPACITY) begin
        growing = 1'b0;
      end else if (mirror_count == 0) begin
        growing = 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        growing = !growing;
      end
      cmd = pick_command(growing);
      send_cmd(cmd, pick_value());
      if (cmd <= CMD_DUMP) begin
        done++;
      end
    end
  endtask

  initial begin : main
    int waited;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_edges();
    test_full_and_wrap();
    test_output_backpressure();
    test_random_traffic();

    in_valid <= 1'b0;
    waited = 0;
    while (due_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // unknown codes give nothing; let stray beats show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_replies.size() != 0) begin
      $display("%0t: %0d result beats never arrived, expected status=%0d entry=%0d",
               $time, due_replies.size(), due_replies[0].status, due_replies[0].entry);
      n_errors++;
    end

    $display("covered %0d commands incl. %0d dumps, %0d result beats checked",
             n_sent, n_dumps, n_checked);
    $display("%0d refused pushes, %0d empty replies, %0d input stall cycles",
             n_full, n_empty, n_in_stalls);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
